### hw/rtl/ibm_pkg.sv
`timescale 1ns / 1ps

package ibm_pkg;

   localparam int DEFAULT_SLOTS = 64;

   localparam int CMD_W       = 2;
   localparam int SLOT_W      = 6;
   localparam int COUNT_W     = 32;
   localparam int WINDOW_W    = 40;
   localparam int TIME_W      = 64;
   localparam int VERDICT_W   = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int DIV_CNT_W   = $clog2(WINDOW_W);

   localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET_OVR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLR_OVR = 2'd2;

   localparam logic [VERDICT_W-1:0] VERDICT_NONE  = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_LOG   = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_ALERT = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MONITOR_ENABLE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG_THRESHOLD   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALERT_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALERT_ENABLE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE        = 3'd4;

   localparam logic [COUNT_W-1:0] RST_LOG_THRESHOLD   = 32'd666666;
   localparam logic [COUNT_W-1:0] RST_ALERT_THRESHOLD = 32'd200000;
   localparam logic [TIME_W-1:0]  RST_DEBOUNCE        = 64'd5000000000;

   // largest increase that still gives an interval: half the 32-bit count range
   localparam logic [COUNT_W-1:0] INC_MAX = 32'h7FFF_FFFF;

endpackage

### hw/rtl/ibm_req_if.sv
`timescale 1ns / 1ps

interface ibm_req_if import ibm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [SLOT_W-1:0]   slot;
   logic [COUNT_W-1:0]  count_now;
   logic [WINDOW_W-1:0] window_ns;
   logic [TIME_W-1:0]   now_ns;
   logic                has_action;
   logic                is_ipi;
   logic [COUNT_W-1:0]  override_value;

   modport source (
      output valid, command, slot, count_now, window_ns, now_ns, has_action, is_ipi,
             override_value,
      input  ready
   );

   modport sink (
      input  valid, command, slot, count_now, window_ns, now_ns, has_action, is_ipi,
             override_value,
      output ready
   );
endinterface

### hw/rtl/ibm_rsp_if.sv
`timescale 1ns / 1ps

interface ibm_rsp_if import ibm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [VERDICT_W-1:0] verdict;
   logic [COUNT_W-1:0]   increase;
   logic [WINDOW_W-1:0]  average_interval_ns;
   logic [SLOT_W-1:0]    slot_out;

   modport source (
      output valid, verdict, increase, average_interval_ns, slot_out,
      input  ready
   );

   modport sink (
      input  valid, verdict, increase, average_interval_ns, slot_out,
      output ready
   );
endinterface

### hw/rtl/interrupt_burst_monitor_core.sv
// A divided sample passes through the read state, the divide steps, evaluation and done
// before its result is valid; every other item goes from read straight to done.
// One item is in work at a time; a sample is divided by the 40-step bit-serial divider,
// and the next item is taken once the previous result is in the output register.
// Reset (synchronous): seen and override valid bits clear, control and CSR registers take
// their defaults; count and period memories are not cleared, entries gated by those bits.
`timescale 1ns / 1ps

module interrupt_burst_monitor_core import ibm_pkg::*; #(
   parameter int SLOTS = DEFAULT_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   ibm_req_if.sink                req_if,
   ibm_rsp_if.source              rsp_if
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_EVAL = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [COUNT_W-1:0] count_mem  [SLOTS];
   logic [COUNT_W-1:0] period_mem [SLOTS];
   logic [COUNT_W-1:0] count_rd_ff;
   logic [COUNT_W-1:0] period_rd_ff;

   logic [2:0]           state_ff, state_in;
   logic [SLOTS-1:0]     seen_ff, seen_in;
   logic [SLOTS-1:0]     ovr_valid_ff, ovr_valid_in;
   logic                 mon_en_ff, mon_en_in;
   logic [COUNT_W-1:0]   log_thr_ff, log_thr_in;
   logic [COUNT_W-1:0]   alert_thr_ff, alert_thr_in;
   logic                 alert_en_ff, alert_en_in;
   logic [TIME_W-1:0]    debounce_ff, debounce_in;
   logic [TIME_W-1:0]    last_alert_ff, last_alert_in;

   logic [CMD_W-1:0]     cmd_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 in_range_ff;
   logic [COUNT_W-1:0]   count_now_ff;
   logic [TIME_W-1:0]    now_ff;
   logic                 has_action_ff;
   logic                 ipi_ff;
   logic [COUNT_W-1:0]   ovr_value_ff;

   logic [COUNT_W-1:0]   inc_ff, inc_in;
   logic [WINDOW_W-1:0]  quo_ff, quo_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic [VERDICT_W-1:0] res_verdict_ff, res_verdict_in;
   logic [WINDOW_W-1:0]  res_avg_ff, res_avg_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0] rsp_verdict_ff;
   logic [COUNT_W-1:0]   rsp_inc_ff;
   logic [WINDOW_W-1:0]  rsp_avg_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;

   logic                 accept;
   logic [IDX_W-1:0]     req_idx;
   logic                 count_we;
   logic                 period_we;
   logic                 rsp_load;
   logic [COUNT_W-1:0]   inc_calc;
   logic [COUNT_W:0]     rem_shift;
   logic                 rem_ge;
   logic                 ovr_block;
   logic                 db_block;

   assign accept    = req_if.valid && req_if.ready;
   assign req_idx   = IDX_W'(req_if.slot);
   assign inc_calc  = count_now_ff - count_rd_ff;
   assign rem_shift = {rem_ff, quo_ff[WINDOW_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, inc_ff};
   assign ovr_block = ovr_valid_ff[idx_ff] && (quo_ff > WINDOW_W'(period_rd_ff));
   assign db_block  = (last_alert_ff != '0) && (debounce_ff != '0) &&
                      ((now_ff - last_alert_ff) < debounce_ff);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   assign req_if.ready               = (state_ff == ST_IDLE);
   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.verdict             = rsp_verdict_ff;
   assign rsp_if.increase            = rsp_inc_ff;
   assign rsp_if.average_interval_ns = rsp_avg_ff;
   assign rsp_if.slot_out            = rsp_slot_ff;

   always_comb begin
      state_in       = state_ff;
      seen_in        = seen_ff;
      ovr_valid_in   = ovr_valid_ff;
      mon_en_in      = mon_en_ff;
      log_thr_in     = log_thr_ff;
      alert_thr_in   = alert_thr_ff;
      alert_en_in    = alert_en_ff;
      debounce_in    = debounce_ff;
      last_alert_in  = last_alert_ff;
      inc_in         = inc_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      res_verdict_in = res_verdict_ff;
      res_avg_in     = res_avg_ff;
      rsp_valid_in   = rsp_valid_ff;
      count_we       = 1'b0;
      period_we      = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_MONITOR_ENABLE:  mon_en_in    = csr_wdata[0];
            CSR_LOG_THRESHOLD:   log_thr_in   = csr_wdata[COUNT_W-1:0];
            CSR_ALERT_THRESHOLD: alert_thr_in = csr_wdata[COUNT_W-1:0];
            CSR_ALERT_ENABLE:    alert_en_in  = csr_wdata[0];
            CSR_DEBOUNCE:        debounce_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            res_verdict_in = VERDICT_NONE;
            res_avg_in     = '0;
            inc_in         = '0;
            state_in       = ST_DONE;
            if (in_range_ff) begin
               case (cmd_ff)
                  CMD_SET_OVR: begin
                     period_we            = 1'b1;
                     ovr_valid_in[idx_ff] = 1'b1;
                  end
                  CMD_CLR_OVR: begin
                     ovr_valid_in[idx_ff] = 1'b0;
                  end
                  CMD_SAMPLE: begin
                     if (mon_en_ff) begin
                        count_we = 1'b1;
                        if (!seen_ff[idx_ff]) begin
                           seen_in[idx_ff] = 1'b1;
                        end else begin
                           inc_in = inc_calc;
                           if ((inc_calc != '0) && (inc_calc <= INC_MAX) && has_action_ff) begin
                              rem_in     = '0;
                              div_cnt_in = DIV_CNT_W'(WINDOW_W - 1);
                              state_in   = ST_DIV;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            quo_in = {quo_ff[WINDOW_W-2:0], rem_ge};
            rem_in = rem_ge ? COUNT_W'(rem_shift - {1'b0, inc_ff}) : rem_shift[COUNT_W-1:0];
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            res_avg_in = quo_ff;
            state_in   = ST_DONE;
            if (quo_ff <= WINDOW_W'(log_thr_ff)) begin
               res_verdict_in = VERDICT_LOG;
               if (!ovr_block && !ipi_ff && (alert_thr_ff != '0) &&
                   (quo_ff < WINDOW_W'(alert_thr_ff)) && alert_en_ff && !db_block) begin
                  res_verdict_in = VERDICT_ALERT;
                  last_alert_in  = now_ff;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (count_we) begin
         count_mem[idx_ff] <= count_now_ff;
      end
      if (period_we) begin
         period_mem[idx_ff] <= ovr_value_ff;
      end
      if (accept) begin
         count_rd_ff  <= count_mem[req_idx];
         period_rd_ff <= period_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= req_if.command;
         slot_ff       <= req_if.slot;
         idx_ff        <= req_idx;
         in_range_ff   <= 32'(req_if.slot) < SLOTS;
         count_now_ff  <= req_if.count_now;
         now_ff        <= req_if.now_ns;
         has_action_ff <= req_if.has_action;
         ipi_ff        <= req_if.is_ipi;
         ovr_value_ff  <= req_if.override_value;
         quo_ff        <= req_if.window_ns;
      end else begin
         quo_ff <= quo_in;
      end
      inc_ff         <= inc_in;
      rem_ff         <= rem_in;
      div_cnt_ff     <= div_cnt_in;
      res_verdict_ff <= res_verdict_in;
      res_avg_ff     <= res_avg_in;
      if (rsp_load) begin
         rsp_verdict_ff <= res_verdict_ff;
         rsp_inc_ff     <= inc_ff;
         rsp_avg_ff     <= res_avg_ff;
         rsp_slot_ff    <= slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seen_ff       <= '0;
         ovr_valid_ff  <= '0;
         mon_en_ff     <= 1'b1;
         log_thr_ff    <= RST_LOG_THRESHOLD;
         alert_thr_ff  <= RST_ALERT_THRESHOLD;
         alert_en_ff   <= 1'b1;
         debounce_ff   <= RST_DEBOUNCE;
         last_alert_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seen_ff       <= seen_in;
         ovr_valid_ff  <= ovr_valid_in;
         mon_en_ff     <= mon_en_in;
         log_thr_ff    <= log_thr_in;
         alert_thr_ff  <= alert_thr_in;
         alert_en_ff   <= alert_en_in;
         debounce_ff   <= debounce_in;
         last_alert_ff <= last_alert_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_READ))
      else $error("accepted item did not enter the read state");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && (div_cnt_ff != '0) |=> (state_ff == ST_DIV))
      else $error("divider left before its last step");

   a_alert_below_thr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_verdict_ff == VERDICT_ALERT) |->
         (rsp_avg_ff < WINDOW_W'(alert_thr_ff)) && (rsp_inc_ff != '0))
      else $error("alert item with interval not below the alert threshold");

   a_alert_stamps_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) && (res_verdict_in == VERDICT_ALERT) |=>
         (last_alert_ff == now_ff))
      else $error("alert did not record its time");

   a_verdict_has_increase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_verdict_ff != VERDICT_NONE) |-> (rsp_inc_ff <= INC_MAX))
      else $error("verdict given for an out-of-range increase");

endmodule
